@@ design/pfrr_pkg.sv @@
package pfrr_pkg;

    localparam int VIRT_PAGES_DEF = 4096;
    localparam int PHYS_PAGES_DEF = 256;

    localparam int ADDR_W     = 24;
    localparam int PAGE_W     = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W    = 8;
    localparam int ACTION_W   = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TLB_ADD = 3'd0,
        ACT_TLB_DEL = 3'd1,
        ACT_STORE   = 3'd2,
        ACT_FETCH   = 3'd3,
        ACT_INVALID = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_DEL,
        ST_FETCH,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic    load_addr;
        logic    clear_step;
        logic    emit;
        t_action action;
        logic    last;
        logic    src_hit;
        logic    clr_fwd;
        logic    set_maps;
        logic    adv_ptr;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic hit;
        logic rev_valid;
        logic out_free;
        logic clear_done;
    } t_dp_sts;

endpackage

@@ design/pfrr_ctrl.sv @@
module pfrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pfrr_pkg::t_dp_sts i_sts,
    output pfrr_pkg::t_dp_cmd o_cmd
);

    pfrr_pkg::t_state r_state;
    pfrr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfrr_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfrr_pkg::ST_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = pfrr_pkg::ST_IDLE;
                end
            end
            pfrr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pfrr_pkg::ST_READ;
                end
            end
            pfrr_pkg::ST_READ: begin
                n_state = pfrr_pkg::ST_DECIDE;
            end
            pfrr_pkg::ST_DECIDE: begin
                if (i_sts.invalid || i_sts.hit) begin
                    if (i_sts.out_free) begin
                        n_state = pfrr_pkg::ST_IDLE;
                    end
                end else if (i_sts.rev_valid) begin
                    if (i_sts.out_free) begin
                        n_state = pfrr_pkg::ST_DEL;
                    end
                end else begin
                    n_state = pfrr_pkg::ST_DEL;
                end
            end
            pfrr_pkg::ST_DEL: begin
                if (i_sts.out_free) begin
                    n_state = pfrr_pkg::ST_FETCH;
                end
            end
            pfrr_pkg::ST_FETCH: begin
                if (i_sts.out_free) begin
                    n_state = pfrr_pkg::ST_ADD;
                end
            end
            pfrr_pkg::ST_ADD: begin
                if (i_sts.out_free) begin
                    n_state = pfrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfrr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.action = pfrr_pkg::ACT_TLB_ADD;
        o_stall      = 1'b1;
        unique case (r_state)
            pfrr_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            pfrr_pkg::ST_IDLE: begin
                o_stall         = 1'b0;
                o_cmd.load_addr = i_valid;
            end
            pfrr_pkg::ST_READ: begin
            end
            pfrr_pkg::ST_DECIDE: begin
                if (i_sts.invalid) begin
                    o_cmd.emit   = i_sts.out_free;
                    o_cmd.action = pfrr_pkg::ACT_INVALID;
                    o_cmd.last   = 1'b1;
                end else if (i_sts.hit) begin
                    o_cmd.emit    = i_sts.out_free;
                    o_cmd.action  = pfrr_pkg::ACT_TLB_ADD;
                    o_cmd.last    = 1'b1;
                    o_cmd.src_hit = 1'b1;
                end else if (i_sts.rev_valid) begin
                    o_cmd.emit    = i_sts.out_free;
                    o_cmd.action  = pfrr_pkg::ACT_STORE;
                    o_cmd.clr_fwd = i_sts.out_free;
                end
            end
            pfrr_pkg::ST_DEL: begin
                o_cmd.emit   = i_sts.out_free;
                o_cmd.action = pfrr_pkg::ACT_TLB_DEL;
            end
            pfrr_pkg::ST_FETCH: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.action   = pfrr_pkg::ACT_FETCH;
                o_cmd.set_maps = i_sts.out_free;
            end
            pfrr_pkg::ST_ADD: begin
                o_cmd.emit    = i_sts.out_free;
                o_cmd.action  = pfrr_pkg::ACT_TLB_ADD;
                o_cmd.last    = 1'b1;
                o_cmd.adv_ptr = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/pfrr_dpath.sv @@
module pfrr_dpath #(
    parameter int VIRT_PAGES = pfrr_pkg::VIRT_PAGES_DEF,
    parameter int PHYS_PAGES = pfrr_pkg::PHYS_PAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pfrr_pkg::ADDR_W-1:0]    i_fault_addr,
    input  logic [pfrr_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [pfrr_pkg::ACTION_W-1:0]  o_action,
    output logic [pfrr_pkg::PAGE_W-1:0]    o_virt_page,
    output logic [pfrr_pkg::FRAME_W-1:0]   o_phys_page,
    output logic                           o_last,
    input  pfrr_pkg::t_dp_cmd              i_cmd,
    output pfrr_pkg::t_dp_sts              o_sts
);

    localparam int FW_AW     = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
    localparam int RV_AW     = (PHYS_PAGES > 1) ? $clog2(PHYS_PAGES) : 1;
    localparam int CLR_DEPTH = (VIRT_PAGES > PHYS_PAGES) ? VIRT_PAGES : PHYS_PAGES;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int FW_DW     = pfrr_pkg::FRAME_W + 1;
    localparam int RV_DW     = pfrr_pkg::PAGE_W + 1;

    localparam logic [CLR_W-1:0]            CLR_LAST     = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W:0]              CLR_VIRT_LIM = (CLR_W + 1)'(VIRT_PAGES);
    localparam logic [CLR_W:0]              CLR_PHYS_LIM = (CLR_W + 1)'(PHYS_PAGES);
    localparam logic [pfrr_pkg::PAGE_W:0]   PAGE_LIM     = (pfrr_pkg::PAGE_W + 1)'(VIRT_PAGES);
    localparam logic [pfrr_pkg::FRAME_W:0]  PTR_LIM      = (pfrr_pkg::FRAME_W + 1)'(PHYS_PAGES);
    localparam logic [pfrr_pkg::FRAME_W-1:0] PTR_FIRST   = pfrr_pkg::FRAME_W'(1);

    logic [pfrr_pkg::ADDR_W-1:0]  r_reject;
    logic [pfrr_pkg::ADDR_W-1:0]  r_addr;
    logic [pfrr_pkg::FRAME_W-1:0] r_ptr;
    logic [pfrr_pkg::FRAME_W-1:0] n_ptr;
    logic [pfrr_pkg::FRAME_W:0]   ptr_inc;
    logic [CLR_W-1:0]             r_clr;

    logic [FW_DW-1:0] r_fwd_mem [VIRT_PAGES];
    logic [RV_DW-1:0] r_rev_mem [PHYS_PAGES];
    logic [FW_DW-1:0] r_fwd_q;
    logic [RV_DW-1:0] r_rev_q;

    logic             fwd_we;
    logic [FW_AW-1:0] fwd_wa;
    logic [FW_DW-1:0] fwd_wd;
    logic             rev_we;
    logic [RV_AW-1:0] rev_wa;
    logic [RV_DW-1:0] rev_wd;

    logic [pfrr_pkg::PAGE_W-1:0] page;
    logic [pfrr_pkg::PAGE_W-1:0] old_page;
    logic                        out_free;

    logic                          r_out_valid;
    logic [pfrr_pkg::ACTION_W-1:0] r_action;
    logic [pfrr_pkg::PAGE_W-1:0]   r_virt_page;
    logic [pfrr_pkg::FRAME_W-1:0]  r_phys_page;
    logic                          r_last;
    logic [pfrr_pkg::PAGE_W-1:0]   n_virt_page;
    logic [pfrr_pkg::FRAME_W-1:0]  n_phys_page;

    assign page     = r_addr[pfrr_pkg::PAGE_SHIFT +: pfrr_pkg::PAGE_W];
    assign old_page = r_rev_q[pfrr_pkg::PAGE_W-1:0];
    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.invalid    = (r_addr == r_reject) || ({1'b0, page} >= PAGE_LIM);
    assign o_sts.hit        = r_fwd_q[FW_DW-1];
    assign o_sts.rev_valid  = r_rev_q[RV_DW-1];
    assign o_sts.out_free   = out_free;
    assign o_sts.clear_done = (r_clr == CLR_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject <= '0;
        end else if (i_cfg_valid) begin
            r_reject <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_addr) begin
            r_addr <= i_fault_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step && (r_clr != CLR_LAST)) begin
            r_clr <= r_clr + CLR_W'(1);
        end
    end

    assign ptr_inc = {1'b0, r_ptr} + (pfrr_pkg::FRAME_W + 1)'(1);

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.adv_ptr) begin
            n_ptr = (ptr_inc >= PTR_LIM) ? PTR_FIRST : ptr_inc[pfrr_pkg::FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= PTR_FIRST;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    always_comb begin
        fwd_we = 1'b0;
        fwd_wa = '0;
        fwd_wd = '0;
        rev_we = 1'b0;
        rev_wa = '0;
        rev_wd = '0;
        if (i_cmd.clear_step) begin
            fwd_we = ({1'b0, r_clr} < CLR_VIRT_LIM);
            fwd_wa = r_clr[FW_AW-1:0];
            rev_we = ({1'b0, r_clr} < CLR_PHYS_LIM);
            rev_wa = r_clr[RV_AW-1:0];
        end else if (i_cmd.clr_fwd) begin
            fwd_we = 1'b1;
            fwd_wa = old_page[FW_AW-1:0];
        end else if (i_cmd.set_maps) begin
            fwd_we = 1'b1;
            fwd_wa = page[FW_AW-1:0];
            fwd_wd = {1'b1, r_ptr};
            rev_we = 1'b1;
            rev_wa = r_ptr[RV_AW-1:0];
            rev_wd = {1'b1, page};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_wa] <= fwd_wd;
        end
        r_fwd_q <= r_fwd_mem[page[FW_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rev_we) begin
            r_rev_mem[rev_wa] <= rev_wd;
        end
        r_rev_q <= r_rev_mem[r_ptr[RV_AW-1:0]];
    end

    always_comb begin
        n_virt_page = page;
        n_phys_page = r_ptr;
        case (i_cmd.action)
            pfrr_pkg::ACT_INVALID: begin
                n_phys_page = '0;
            end
            pfrr_pkg::ACT_TLB_ADD: begin
                if (i_cmd.src_hit) begin
                    n_phys_page = r_fwd_q[pfrr_pkg::FRAME_W-1:0];
                end
            end
            pfrr_pkg::ACT_STORE: begin
                n_virt_page = old_page;
            end
            pfrr_pkg::ACT_TLB_DEL: begin
                n_virt_page = '0;
            end
            pfrr_pkg::ACT_FETCH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_action    <= i_cmd.action;
            r_virt_page <= n_virt_page;
            r_phys_page <= n_phys_page;
            r_last      <= i_cmd.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_action    = r_action;
    assign o_virt_page = r_virt_page;
    assign o_phys_page = r_phys_page;
    assign o_last      = r_last;

endmodule

@@ design/page_fault_round_robin_mapper.sv @@
// Page-fault mapper with demand paging and round-robin frame replacement. Each item is one
// faulting address; it produces one command (invalid fault or TLB add on a hit) or, on a
// miss, an optional swap store of the evicted page, then TLB delete, swap fetch and TLB add,
// with last set on the final command. Frames are handed out round robin from 1 upwards,
// frame 0 is never used. One item is worked at a time: a rejected address or a hit goes
// through read and decide, its command loaded in decide; a miss goes on through delete,
// fetch and add, its last command loaded in add. Each command waits while the output
// stalls. The sequence is set by the registered reads of the forward and reverse page
// tables and by the single write port of each table. After reset both tables are swept
// clear, one entry per cycle, over max(VIRT_PAGES, PHYS_PAGES) entries, during which no
// item is taken. The reject address register may be written at any time the block is idle.
module page_fault_round_robin_mapper #(
    parameter int VIRT_PAGES = pfrr_pkg::VIRT_PAGES_DEF,
    parameter int PHYS_PAGES = pfrr_pkg::PHYS_PAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [pfrr_pkg::ADDR_W-1:0]    i_fault_addr,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [pfrr_pkg::ACTION_W-1:0]  o_action,
    output logic [pfrr_pkg::PAGE_W-1:0]    o_virt_page,
    output logic [pfrr_pkg::FRAME_W-1:0]   o_phys_page,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfrr_pkg::ADDR_W-1:0]    i_cfg_data
);

    pfrr_pkg::t_dp_cmd dp_cmd;
    pfrr_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    pfrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    pfrr_dpath #(
        .VIRT_PAGES (VIRT_PAGES),
        .PHYS_PAGES (PHYS_PAGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fault_addr (i_fault_addr),
        .i_cfg_data   (i_cfg_data),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_action     (o_action),
        .o_virt_page  (o_virt_page),
        .o_phys_page  (o_phys_page),
        .o_last       (o_last),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts)
    );

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_sts.out_free)
        else $error("command loaded while output register busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("new item taken while previous one in progress");

    a_map_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.set_maps |-> (!dp_sts.hit && !dp_sts.invalid))
        else $error("tables updated for a hit or rejected fault");

    a_one_table_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.clear_step, dp_cmd.clr_fwd, dp_cmd.set_maps, dp_cmd.load_addr}))
        else $error("conflicting table operations");
`endif

endmodule
